@@ rtl/call_stack_profiler_unit_macros.svh @@
// assertion macros for the call stack profiler checker
// expects a clock named aclk and an active low reset named aresetn in scope
`ifndef CALL_STACK_PROFILER_UNIT_MACROS_SVH
`define CALL_STACK_PROFILER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CSPU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define CSPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define CSPU_ASSERT_NR(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cspu_pkg.sv @@
// shared types, constants and helpers for the call stack profiler
// no dependencies
`default_nettype none

package cspu_pkg;

    localparam int TABLE_BITS_DEF  = 10;
    localparam int STACK_DEPTH_DEF = 256;

    localparam logic [63:0] HASH_MUL   = 64'h9E3779B97F4A7C15;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [8:0]  ACTIVE_MAX = 9'h1FF;

    typedef enum logic [1:0] {
        REQ_ENTER = 2'd0,
        REQ_EXIT  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_UNWOUND   = 3'd2,
        STS_UNMATCHED = 3'd3,
        STS_IGNORED   = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_START, S_TOP, S_CHARGE,
        S_HASH0, S_HASH1, S_HASH2, S_PROBE, S_PCHK,
        S_XCHK, S_SRCH, S_CLRD, S_CLSTK, S_CLTBL,
        S_FINISH, S_READ, S_CLR_RD, S_CLR_WR, S_OUT
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [63:0] start_time;
        logic [63:0] end_time;
        logic [10:0] entry_index;
    } cspu_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  unwound_frames;
        logic [63:0] entry_key;
        logic [31:0] entry_calls;
        logic [31:0] entry_child_calls;
        logic [63:0] entry_self;
        logic [63:0] entry_inclusive;
        logic [63:0] root_time;
        logic [31:0] unmatched_count;
        logic [31:0] overflow_count;
        logic [31:0] event_count;
        logic [63:0] hook_time;
    } cspu_out_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/call_stack_profiler_unit.sv @@
// call stack profiler: statistics table, frame stack and sequencer in one module
// depends on cspu_pkg
`default_nettype none

// Usage
//   s_valid/s_ready take one request item (enter, exit, table read, window clear);
//   m_valid/m_ready return exactly one result item per request, holding the
//   running totals after that request. cfg_wr_en/cfg_wr_data set the enable bit
//   and must only be written while the block is idle.
// Sequencing
//   One item at a time. An enter reads the table once per probe; the hash
//   is three passes through one 32x32 multiplier. An exit reads the stack
//   once per frame searched, from the top down, and closes each frame with a
//   stack read, a table read and a write back. A read is one table read; a
//   window clear reads and writes back each of the 2^TABLE_BITS+1 table
//   entries through the table port.
// Reset
//   After reset the table is swept to zero, one entry per cycle, all
//   2^TABLE_BITS+1 entries; s_ready stays low meanwhile. Config writes are taken.
// Stall
//   A finished result waits in the output register; the next item is taken
//   meanwhile and its result waits until the output register is free.
module call_stack_profiler_unit #(
    parameter int TABLE_BITS  = cspu_pkg::TABLE_BITS_DEF,
    parameter int STACK_DEPTH = cspu_pkg::STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  cspu_pkg::cspu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cspu_pkg::cspu_out_t m_data
);
    import cspu_pkg::*;

    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int AW    = TABLE_BITS + 1;
    localparam int SW    = $clog2(STACK_DEPTH);
    localparam int DW    = $clog2(STACK_DEPTH + 1);
    localparam logic [AW-1:0] SPILL = AW'(TSIZE);

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] calls;
        logic [31:0] child;
        logic [63:0] self_t;
        logic [63:0] incl;
        logic [8:0]  active;
    } tbl_ent_t;

    typedef struct packed {
        logic [AW-1:0] entry;
        logic [63:0]   fkey;
        logic [63:0]   enter_time;
        logic [63:0]   excl_at;
        logic          outermost;
    } frame_t;

    // memories
    tbl_ent_t tbl_mem [TSIZE+1];
    frame_t   stk_mem [STACK_DEPTH];

    tbl_ent_t      tbl_rdata_reg, tbl_wdata;
    logic          tbl_we, tbl_re;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    frame_t        stk_rdata_reg, stk_wdata;
    logic          stk_we, stk_re;
    logic [SW-1:0] stk_waddr, stk_raddr;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // control and totals
    fsm_state_t    state_reg, state_next;
    logic          enabled_reg, enabled_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0]   pending_reg, pending_next;
    logic [63:0]   excl_reg, excl_next;
    logic [63:0]   last_reg, last_next;
    logic [63:0]   root_reg, root_next;
    logic [63:0]   hook_reg, hook_next;
    logic [31:0]   event_reg, event_next;
    logic [31:0]   unm_reg, unm_next;
    logic [31:0]   ovf_reg, ovf_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          m_valid_reg, m_valid_next;

    // per-item working registers
    cspu_in_t          req_reg, req_next;
    logic [63:0]       delta_reg, delta_next;
    logic [63:0]       hookd_reg, hookd_next;
    logic [63:0]       acc_reg, acc_next;
    logic [AW-1:0]     probe_reg, probe_next;
    logic [TABLE_BITS-1:0] pcnt_reg, pcnt_next;
    logic              spill_reg, spill_next;
    logic [AW-1:0]     top_entry_reg, top_entry_next;
    logic [SW-1:0]     srch_reg, srch_next;
    logic [DW-1:0]     target_reg, target_next;
    logic [63:0]       a_reg, a_next;
    logic [63:0]       b_reg, b_next;
    logic              outer_reg, outer_next;
    logic [AW-1:0]     cl_entry_reg, cl_entry_next;
    status_t           status_reg, status_next;
    logic [8:0]        unwound_reg, unwound_next;
    tbl_ent_t          rd_ent_reg, rd_ent_next;
    cspu_out_t         m_data_reg, m_data_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] idx_w;
    logic        is_enter;

    assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
    assign idx_w    = 32'(s_data.entry_index);
    assign is_enter = (req_reg.req_type == REQ_ENTER);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            enabled_reg <= 1'b0;
            depth_reg   <= '0;
            pending_reg <= '0;
            excl_reg    <= '0;
            last_reg    <= '0;
            root_reg    <= '0;
            hook_reg    <= '0;
            event_reg   <= '0;
            unm_reg     <= '0;
            ovf_reg     <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            enabled_reg <= enabled_next;
            depth_reg   <= depth_next;
            pending_reg <= pending_next;
            excl_reg    <= excl_next;
            last_reg    <= last_next;
            root_reg    <= root_next;
            hook_reg    <= hook_next;
            event_reg   <= event_next;
            unm_reg     <= unm_next;
            ovf_reg     <= ovf_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        delta_reg     <= delta_next;
        hookd_reg     <= hookd_next;
        acc_reg       <= acc_next;
        probe_reg     <= probe_next;
        pcnt_reg      <= pcnt_next;
        spill_reg     <= spill_next;
        top_entry_reg <= top_entry_next;
        srch_reg      <= srch_next;
        target_reg    <= target_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        outer_reg     <= outer_next;
        cl_entry_reg  <= cl_entry_next;
        status_reg    <= status_next;
        unwound_reg   <= unwound_next;
        rd_ent_reg    <= rd_ent_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        enabled_next   = cfg_wr_en ? cfg_wr_data : enabled_reg;
        depth_next     = depth_reg;
        pending_next   = pending_reg;
        excl_next      = excl_reg;
        last_next      = last_reg;
        root_next      = root_reg;
        hook_next      = hook_reg;
        event_next     = event_reg;
        unm_next       = unm_reg;
        ovf_next       = ovf_reg;
        sweep_next     = sweep_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        req_next       = req_reg;
        delta_next     = delta_reg;
        hookd_next     = hookd_reg;
        acc_next       = acc_reg;
        probe_next     = probe_reg;
        pcnt_next      = pcnt_reg;
        spill_next     = spill_reg;
        top_entry_next = top_entry_reg;
        srch_next      = srch_reg;
        target_next    = target_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        outer_next     = outer_reg;
        cl_entry_next  = cl_entry_reg;
        status_next    = status_reg;
        unwound_next   = unwound_reg;
        rd_ent_next    = rd_ent_reg;
        m_data_next    = m_data_reg;

        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_waddr = '0;
        tbl_raddr = '0;
        tbl_wdata = tbl_rdata_reg;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = '0;
        stk_raddr = '0;
        stk_wdata = '0;
        mul_a     = req_reg.key[31:0];
        mul_b     = HASH_MUL[31:0];

        case (state_reg)
            S_INIT: begin
                tbl_we    = 1'b1;
                tbl_waddr = sweep_reg;
                tbl_wdata = '0;
                if (sweep_reg == SPILL) begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data;
                    delta_next   = s_data.start_time - last_reg;
                    hookd_next   = s_data.end_time - s_data.start_time;
                    status_next  = STS_OK;
                    unwound_next = '0;
                    rd_ent_next  = '0;
                    case (s_data.req_type)
                        REQ_ENTER, REQ_EXIT: begin
                            if (!enabled_reg || s_data.key == 64'd0) begin
                                status_next = STS_IGNORED;
                                state_next  = S_OUT;
                            end else begin
                                state_next = S_START;
                            end
                        end
                        REQ_READ: begin
                            tbl_re     = 1'b1;
                            tbl_raddr  = (idx_w >= 32'(TSIZE)) ? SPILL : AW'(idx_w);
                            state_next = S_READ;
                        end
                        default: begin
                            sweep_next = '0;
                            state_next = S_CLR_RD;
                        end
                    endcase
                end
            end
            S_START: begin
                if (depth_reg != '0) begin
                    stk_re     = 1'b1;
                    stk_raddr  = SW'(depth_reg - DW'(1));
                    state_next = S_TOP;
                end else begin
                    root_next  = root_reg + delta_reg;
                    state_next = is_enter ? S_HASH0 : S_XCHK;
                end
            end
            S_TOP: begin
                top_entry_next = stk_rdata_reg.entry;
                tbl_re         = 1'b1;
                tbl_raddr      = stk_rdata_reg.entry;
                state_next     = S_CHARGE;
            end
            S_CHARGE: begin
                // self time to the top frame, child call to the caller on enter
                tbl_we           = 1'b1;
                tbl_waddr        = top_entry_reg;
                tbl_wdata.self_t = tbl_rdata_reg.self_t + delta_reg;
                if (is_enter) begin
                    tbl_wdata.child = sat_inc32(tbl_rdata_reg.child);
                end
                state_next = is_enter ? S_HASH0 : S_XCHK;
            end
            S_HASH0: begin
                acc_next   = mul_p;
                state_next = S_HASH1;
            end
            S_HASH1: begin
                mul_b      = HASH_MUL[63:32];
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                state_next = S_HASH2;
            end
            S_HASH2: begin
                mul_a      = req_reg.key[63:32];
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                probe_next = {1'b0, acc_next[63 -: TABLE_BITS]};
                pcnt_next  = '0;
                spill_next = 1'b0;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                tbl_re     = 1'b1;
                tbl_raddr  = probe_reg;
                state_next = S_PCHK;
            end
            S_PCHK: begin
                if (spill_reg || tbl_rdata_reg.key == req_reg.key
                        || tbl_rdata_reg.key == 64'd0) begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = probe_reg;
                    tbl_wdata.calls = sat_inc32(tbl_rdata_reg.calls);
                    if (!spill_reg) begin
                        tbl_wdata.key = req_reg.key;
                    end
                    if (depth_reg < DW'(STACK_DEPTH)) begin
                        if (tbl_rdata_reg.active != ACTIVE_MAX) begin
                            tbl_wdata.active = tbl_rdata_reg.active + 9'd1;
                        end
                        stk_we               = 1'b1;
                        stk_waddr            = SW'(depth_reg);
                        stk_wdata.entry      = probe_reg;
                        stk_wdata.fkey       = spill_reg ? 64'd0 : req_reg.key;
                        stk_wdata.enter_time = req_reg.start_time;
                        stk_wdata.excl_at    = excl_reg;
                        stk_wdata.outermost  = (tbl_rdata_reg.active == 9'd0);
                        depth_next           = depth_reg + DW'(1);
                        status_next          = STS_OK;
                    end else begin
                        pending_next = sat_inc32(pending_reg);
                        ovf_next     = sat_inc32(ovf_reg);
                        status_next  = STS_OVERFLOW;
                    end
                    state_next = S_FINISH;
                end else if (pcnt_reg == TABLE_BITS'(TSIZE - 1)) begin
                    // table full: fall back to the shared spill entry
                    spill_next = 1'b1;
                    probe_next = SPILL;
                    tbl_re     = 1'b1;
                    tbl_raddr  = SPILL;
                end else begin
                    probe_next = {1'b0, probe_reg[TABLE_BITS-1:0] + TABLE_BITS'(1)};
                    pcnt_next  = pcnt_reg + TABLE_BITS'(1);
                    tbl_re     = 1'b1;
                    tbl_raddr  = probe_next;
                end
            end
            S_XCHK: begin
                if (pending_reg != 32'd0) begin
                    pending_next = pending_reg - 32'd1;
                    state_next   = S_FINISH;
                end else if (depth_reg == '0) begin
                    unm_next    = sat_inc32(unm_reg);
                    status_next = STS_UNMATCHED;
                    state_next  = S_FINISH;
                end else begin
                    srch_next  = SW'(depth_reg - DW'(1));
                    stk_re     = 1'b1;
                    stk_raddr  = SW'(depth_reg - DW'(1));
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (stk_rdata_reg.fkey == req_reg.key) begin
                    target_next = DW'(srch_reg);
                    if (srch_reg == SW'(depth_reg - DW'(1))) begin
                        status_next = STS_OK;
                    end else begin
                        status_next  = STS_UNWOUND;
                        unwound_next = 9'(depth_reg - DW'(srch_reg));
                    end
                    state_next = S_CLRD;
                end else if (srch_reg == '0) begin
                    unm_next    = sat_inc32(unm_reg);
                    status_next = STS_UNMATCHED;
                    state_next  = S_FINISH;
                end else begin
                    srch_next = srch_reg - SW'(1);
                    stk_re    = 1'b1;
                    stk_raddr = srch_reg - SW'(1);
                end
            end
            S_CLRD: begin
                stk_re     = 1'b1;
                stk_raddr  = SW'(depth_reg - DW'(1));
                state_next = S_CLSTK;
            end
            S_CLSTK: begin
                a_next        = req_reg.start_time - stk_rdata_reg.enter_time;
                b_next        = excl_reg - stk_rdata_reg.excl_at;
                outer_next    = stk_rdata_reg.outermost;
                cl_entry_next = stk_rdata_reg.entry;
                tbl_re        = 1'b1;
                tbl_raddr     = stk_rdata_reg.entry;
                state_next    = S_CLTBL;
            end
            S_CLTBL: begin
                tbl_we    = 1'b1;
                tbl_waddr = cl_entry_reg;
                if (tbl_rdata_reg.active != 9'd0) begin
                    tbl_wdata.active = tbl_rdata_reg.active - 9'd1;
                end
                // inclusive time only for the outermost activation
                if (outer_reg) begin
                    tbl_wdata.incl = tbl_rdata_reg.incl + a_reg - b_reg;
                end
                depth_next = depth_reg - DW'(1);
                state_next = (depth_next == target_reg) ? S_FINISH : S_CLRD;
            end
            S_FINISH: begin
                excl_next  = excl_reg + hookd_reg;
                hook_next  = hook_reg + hookd_reg;
                event_next = sat_inc32(event_reg);
                last_next  = req_reg.end_time;
                state_next = S_OUT;
            end
            S_READ: begin
                rd_ent_next = tbl_rdata_reg;
                state_next  = S_OUT;
            end
            S_CLR_RD: begin
                tbl_re     = 1'b1;
                tbl_raddr  = sweep_reg;
                state_next = S_CLR_WR;
            end
            S_CLR_WR: begin
                tbl_we           = 1'b1;
                tbl_waddr        = sweep_reg;
                tbl_wdata.calls  = '0;
                tbl_wdata.child  = '0;
                tbl_wdata.self_t = '0;
                tbl_wdata.incl   = '0;
                if (sweep_reg == SPILL) begin
                    sweep_next = '0;
                    state_next = S_OUT;
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                    state_next = S_CLR_RD;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status            = status_reg;
                    m_data_next.unwound_frames    = unwound_reg;
                    m_data_next.entry_key         = rd_ent_reg.key;
                    m_data_next.entry_calls       = rd_ent_reg.calls;
                    m_data_next.entry_child_calls = rd_ent_reg.child;
                    m_data_next.entry_self        = rd_ent_reg.self_t;
                    m_data_next.entry_inclusive   = rd_ent_reg.incl;
                    m_data_next.root_time         = root_reg;
                    m_data_next.unmatched_count   = unm_reg;
                    m_data_next.overflow_count    = ovf_reg;
                    m_data_next.event_count       = event_reg;
                    m_data_next.hook_time         = hook_reg;
                    m_valid_next                  = 1'b1;
                    state_next                    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/cspu_checker.sv @@
// port-level checks for the call stack profiler, bound to the top level
// depends on cspu_pkg and call_stack_profiler_unit_macros.svh
`default_nettype none
`include "call_stack_profiler_unit_macros.svh"

module cspu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cspu_pkg::cspu_out_t m_data
);
    import cspu_pkg::*;

    // one item in flight: ready drops right after an accept
    `CSPU_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    // a stalled result holds
    `CSPU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // only an unwinding exit reports closed frames
    `CSPU_ASSERT_SAME(a_unwound_only, m_valid && (m_data.status != STS_UNWOUND), m_data.unwound_frames == 9'd0)
    // reset empties the output and holds off input during the table sweep
    `CSPU_ASSERT_NR(a_reset_quiet, !aresetn, !m_valid && !s_ready)

endmodule

bind call_stack_profiler_unit cspu_checker u_cspu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ test/tb_checker.sv @@
// checker for the call stack profiler: watches both channels, predicts each result
// depends on cspu_pkg and on the enable bit mirrored by the top
module tb_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                enabled,
    input  logic                s_valid,
    input  logic                s_ready,
    input  cspu_pkg::cspu_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cspu_pkg::cspu_out_t m_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cspu_pkg::*;

    localparam int TBITS = 10;
    localparam int TSIZE = 1 << TBITS;
    localparam int SPILL = TSIZE;
    localparam int DEPTH = 256;

    logic [63:0] tab_key   [0:TSIZE];
    logic [31:0] tab_calls [0:TSIZE];
    logic [31:0] tab_child [0:TSIZE];
    logic [63:0] tab_self  [0:TSIZE];
    logic [63:0] tab_incl  [0:TSIZE];
    logic [8:0]  tab_act   [0:TSIZE];
    int          fr_entry  [0:DEPTH-1];
    logic [63:0] fr_t0     [0:DEPTH-1];
    logic [63:0] fr_excl   [0:DEPTH-1];
    logic        fr_outer  [0:DEPTH-1];
    int          depth;
    logic [31:0] ovf_pending, n_events, n_unmatched, n_overflow;
    logic [63:0] excl_total, last_t, root_t, hook_t;

    cspu_out_t expected_results[$];

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int find_slot(input logic [63:0] k);
        logic [63:0] prod;
        int          i;
        prod = k * HASH_MUL;
        i = int'(prod[63:64-TBITS]);
        for (int n = 0; n < TSIZE; n++) begin
            if (tab_key[i] == k) return i;
            if (tab_key[i] == 64'd0) begin
                tab_key[i] = k;
                return i;
            end
            i = (i + 1) % TSIZE;
        end
        return SPILL;
    endfunction

    function automatic void charge(input logic [63:0] now);
        if (depth > 0) tab_self[fr_entry[depth-1]] += now - last_t;
        else root_t += now - last_t;
    endfunction

    function automatic void pop_frame(input logic [63:0] now);
        int e;
        depth--;
        e = fr_entry[depth];
        if (tab_act[e] > 0) tab_act[e]--;
        if (fr_outer[depth])
            tab_incl[e] += (now - fr_t0[depth]) - (excl_total - fr_excl[depth]);
    endfunction

    function automatic cspu_out_t profile_step(input cspu_in_t it);
        cspu_out_t r;
        int        e;
        int        hit;
        r = '0;
        r.status = STS_OK;
        case (req_type_t'(it.req_type))
            REQ_ENTER, REQ_EXIT: begin
                if (!enabled || it.key == 64'd0) begin
                    r.status = STS_IGNORED;
                end else begin
                    charge(it.start_time);
                    if (it.req_type == REQ_ENTER) begin
                        e = find_slot(it.key);
                        tab_calls[e] = bump(tab_calls[e]);
                        if (depth > 0) tab_child[fr_entry[depth-1]] =
                            bump(tab_child[fr_entry[depth-1]]);
                        if (depth < DEPTH) begin
                            fr_entry[depth] = e;
                            fr_t0[depth] = it.start_time;
                            fr_excl[depth] = excl_total;
                            fr_outer[depth] = (tab_act[e] == 0);
                            if (tab_act[e] != 9'h1FF) tab_act[e]++;
                            depth++;
                        end else begin
                            ovf_pending = bump(ovf_pending);
                            n_overflow = bump(n_overflow);
                            r.status = STS_OVERFLOW;
                        end
                    end else if (ovf_pending > 0) begin
                        ovf_pending--;
                    end else if (depth > 0 && tab_key[fr_entry[depth-1]] == it.key) begin
                        pop_frame(it.start_time);
                    end else begin
                        hit = -1;
                        for (int i = depth - 1; i >= 0 && hit < 0; i--)
                            if (tab_key[fr_entry[i]] == it.key) hit = i;
                        if (hit >= 0) begin
                            while (depth > hit) begin
                                pop_frame(it.start_time);
                                r.unwound_frames++;
                            end
                            r.status = STS_UNWOUND;
                        end else begin
                            n_unmatched = bump(n_unmatched);
                            r.status = STS_UNMATCHED;
                        end
                    end
                    excl_total += it.end_time - it.start_time;
                    hook_t += it.end_time - it.start_time;
                    n_events = bump(n_events);
                    last_t = it.end_time;
                end
            end
            REQ_READ: begin
                e = (it.entry_index >= TSIZE) ? SPILL : int'(it.entry_index);
                r.entry_key = tab_key[e];
                r.entry_calls = tab_calls[e];
                r.entry_child_calls = tab_child[e];
                r.entry_self = tab_self[e];
                r.entry_inclusive = tab_incl[e];
            end
            default: begin
                for (int i = 0; i <= SPILL; i++) begin
                    tab_calls[i] = '0;
                    tab_child[i] = '0;
                    tab_self[i] = '0;
                    tab_incl[i] = '0;
                end
            end
        endcase
        r.root_time = root_t;
        r.unmatched_count = n_unmatched;
        r.overflow_count = n_overflow;
        r.event_count = n_events;
        r.hook_time = hook_t;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    assign pending = expected_results.size();

    initial begin
        fail_count = 0;
        for (int i = 0; i <= SPILL; i++) begin
            tab_key[i] = '0; tab_calls[i] = '0; tab_child[i] = '0;
            tab_self[i] = '0; tab_incl[i] = '0; tab_act[i] = '0;
        end
        depth = 0;
        ovf_pending = '0; n_events = '0; n_unmatched = '0; n_overflow = '0;
        excl_total = '0; last_t = '0; root_t = '0; hook_t = '0;
    end

    always @(posedge aclk) begin
        cspu_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_results = {expected_results, profile_step(s_data)};
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_data.status));
                    check_field("unwound_frames", 64'(want.unwound_frames),
                                64'(m_data.unwound_frames));
                    check_field("entry_key", want.entry_key, m_data.entry_key);
                    check_field("entry_calls", 64'(want.entry_calls), 64'(m_data.entry_calls));
                    check_field("entry_child_calls", 64'(want.entry_child_calls),
                                64'(m_data.entry_child_calls));
                    check_field("entry_self", want.entry_self, m_data.entry_self);
                    check_field("entry_inclusive", want.entry_inclusive,
                                m_data.entry_inclusive);
                    check_field("root_time", want.root_time, m_data.root_time);
                    check_field("unmatched_count", 64'(want.unmatched_count),
                                64'(m_data.unmatched_count));
                    check_field("overflow_count", 64'(want.overflow_count),
                                64'(m_data.overflow_count));
                    check_field("event_count", 64'(want.event_count), 64'(m_data.event_count));
                    check_field("hook_time", want.hook_time, m_data.hook_time);
                end
            end
        end
    end
endmodule

@@ test/tb_top.sv @@
// top of the call stack profiler testbench: clock, reset, stimulus and verdict
// depends on cspu_pkg, call_stack_profiler_unit and tb_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cspu_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      enabled = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cspu_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cspu_out_t m_data;
    int        fail_count;
    int        pending;
    int        quiet_cycles = 0;
    bit        sender_quiet = 1'b0;
    bit        receiver_quiet = 1'b0;
    bit        hold_off = 1'b0;
    bit        pressure_go = 1'b0;
    logic [63:0] clock_now = 64'd1000;
    logic [63:0] key_pool[16];

    always #5 aclk = ~aclk;

    call_stack_profiler_unit u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tb_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .enabled(enabled),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        m_ready <= !hold_off && (receiver_quiet || $urandom_range(99) >= 33);
    end

    // long hold-off while the sender keeps offering items
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input req_type_t req, input logic [63:0] k,
                             input logic [63:0] t0, input logic [63:0] t1,
                             input logic [10:0] idx);
        while (!sender_quiet && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{req_type: req, key: k, start_time: t0, end_time: t1, entry_index: idx};
        do @(posedge aclk); while (!s_ready);
    endtask

    // event with timestamps that move forward in small steps
    task automatic send_event(input req_type_t req, input logic [63:0] k);
        logic [63:0] t0;
        t0 = clock_now + $urandom_range(50);
        clock_now = t0 + $urandom_range(20);
        send_item(req, k, t0, clock_now, 11'd0);
    endtask

    task automatic write_enable(input logic v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2200) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        enabled <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_item();
        int sel;
        logic [63:0] k;
        sel = $urandom_range(99);
        k = key_pool[$urandom_range(15)];
        if (sel < 40) send_event(REQ_ENTER, k);
        else if (sel < 80) send_event(REQ_EXIT, k);
        else if (sel < 92) send_item(REQ_READ, {$urandom, $urandom}, {$urandom, $urandom},
                                     {$urandom, $urandom}, 11'($urandom_range(1024)));
        else if (sel < 94) send_item(REQ_CLEAR, '0, '0, '0, '0);
        else send_item(sel[0] ? REQ_ENTER : REQ_EXIT, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom));
    endtask

    initial begin
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;
        key_pool[0] = 64'd1;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[2] = 64'h8000_0000_0000_0000;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // disabled: events are ignored, reads still work
        send_event(REQ_ENTER, key_pool[3]);
        send_item(REQ_READ, '0, '0, '0, 11'd1024);
        write_enable(1'b1);
        send_event(REQ_ENTER, 64'd0);
        send_event(REQ_ENTER, key_pool[0]);
        send_event(REQ_ENTER, key_pool[1]);
        send_event(REQ_ENTER, key_pool[0]);
        send_event(REQ_EXIT, key_pool[0]);
        send_event(REQ_EXIT, key_pool[4]);
        send_event(REQ_ENTER, key_pool[2]);
        send_event(REQ_ENTER, key_pool[5]);
        send_event(REQ_EXIT, key_pool[0]);
        send_item(REQ_ENTER, key_pool[6], 64'hFFFF_FFFF_FFFF_FFF0, 64'd5, 11'd0);
        send_item(REQ_EXIT, key_pool[6], 64'd10, 64'hFFFF_FFFF_FFFF_FFFF, 11'h7FF);
        send_item(REQ_READ, '0, '0, '0, 11'h7FF);
        send_item(REQ_READ, '0, '0, '0, 11'd1023);
        send_item(REQ_CLEAR, '0, '0, '0, '0);
        // fill the stack past its depth, then send exits that the pending overflow count absorbs
        for (int i = 0; i < 260; i++) send_event(REQ_ENTER, key_pool[7 + (i % 3)]);
        send_event(REQ_EXIT, key_pool[9]);
        send_event(REQ_EXIT, key_pool[10]);
        send_event(REQ_EXIT, key_pool[7]);
        sender_quiet = 1'b1;
        receiver_quiet = 1'b1;
        for (int i = 0; i < 300; i++) random_item();
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        pressure_go = 1'b1;
        for (int i = 0; i < 500; i++) random_item();
        write_enable(1'b0);
        for (int i = 0; i < 60; i++) random_item();
        write_enable(1'b1);
        for (int i = 0; i < 400; i++) random_item();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cspu_pkg.sv
rtl/call_stack_profiler_unit.sv
rtl/cspu_checker.sv
test/tb_checker.sv
test/tb_top.sv
